/* rtl/gapf_pkg.sv */
// Package for the grid path finder: shared constants, codes and the control state type.
// No dependencies; imported by the top level and by gapf_best.
package gapf_pkg;

  localparam int MAX_COLS_DEF = 16;
  localparam int MAX_ROWS_DEF = 16;

  localparam int COST_W     = 12;
  localparam int STEP_COST  = 10;
  localparam logic [COST_W-1:0] COST_INF = 12'hFFF;
  localparam int RESULT_CAP = 16;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_DAT_W-1:0] GRID_WIDTH_RST  = 5'd9;
  localparam logic [CFG_DAT_W-1:0] GRID_HEIGHT_RST = 5'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_NB_RD,
    ST_NB_WR,
    ST_CLOSE,
    ST_TR_RD,
    ST_TR_CHK,
    ST_EMIT
  } gapf_state_e;

endpackage

/* rtl/grid_astar_path_finder_top.sv */
// Top level of the grid path finder: control sequencer, cost and predecessor memories, output register.
// Depends on gapf_pkg, gapf_ram and gapf_best.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, start_col/row, move_dir/dist | request in
//  out     | out_valid_o, out_stall_i, path_col/row, found, ...   | result out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i    | reg write
//
// One request at a time. A search first clears the cost memory, then in each pass scans
// the cost memory through its read port and relaxes up to four neighbors, for up to W*H
// passes; trace-back reads the predecessor memory once per result.
// Reset restores grid_width 9 and grid_height 4; memories need no reset sweep.
// A stalled output holds its result; the last result of a request may wait while the next
// request is taken.
module grid_astar_path_finder_top #(
  parameter int MAX_COLS = gapf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gapf_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [3:0]                   start_col_i,
  input  logic [3:0]                   start_row_i,
  input  logic [1:0]                   move_dir_i,
  input  logic [3:0]                   move_dist_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [3:0]                   path_col_o,
  output logic [3:0]                   path_row_o,
  output logic                         found_o,
  output logic                         went_over_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gapf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gapf_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import gapf_pkg::*;

  localparam int CXW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RXW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = COST_W + 1;
  localparam int NW    = $clog2(RESULT_CAP);

  function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] c, input logic [RXW-1:0] r);
    return AW'(int'(c) * MAX_ROWS + int'(r));
  endfunction

  gapf_state_e state_q, state_d;

  logic [CFG_DAT_W-1:0] gw_q, gh_q;
  logic [NCW-1:0] w_eff;
  logic [NRW-1:0] h_eff;
  logic [PW-1:0]  passes;

  logic [CXW-1:0] sc_q, ec_q, sweep_c_q, cur_c_q, scan_c_q;
  logic [RXW-1:0] sr_q, er_q, sweep_r_q, cur_r_q, scan_r_q;
  logic           over_q, emit_found_q, scan_vld_q;
  logic [PW-1:0]  pass_q;
  logic [1:0]     nb_q;
  logic [NW-1:0]  cnt_q;

  logic              out_vld_q, out_found_q, out_over_q, out_last_q;
  logic [3:0]        out_col_q, out_row_q;

  logic accept, out_free, sweep_last;
  logic start_out, start_eq;
  logic [CXW-1:0] ec_new;
  logic [RXW-1:0] er_new;
  logic           over_new;

  logic           cost_we, cost_re, from_we, from_re;
  logic [AW-1:0]  cost_wa, cost_ra, from_ra;
  logic [CW-1:0]  cost_wd, cost_rd;
  logic [CXW+RXW-1:0] from_wd, from_rd;

  logic              best_vld, best_clr;
  logic [CXW-1:0]    best_c;
  logic [RXW-1:0]    best_r;
  logic [COST_W-1:0] best_g;

  logic [CXW-1:0] nb_c;
  logic [RXW-1:0] nb_r;
  logic           nb_ok;
  logic [COST_W:0] g_new;
  logic           relax_hit;
  logic [CXW-1:0] p_c;
  logic [RXW-1:0] p_r;
  logic           tr_last;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;

  // clamp register values into the supported grid
  always_comb begin
    if (gw_q == '0) w_eff = NCW'(1);
    else if (int'(gw_q) > MAX_COLS) w_eff = NCW'(MAX_COLS);
    else w_eff = NCW'(gw_q);
    if (gh_q == '0) h_eff = NRW'(1);
    else if (int'(gh_q) > MAX_ROWS) h_eff = NRW'(MAX_ROWS);
    else h_eff = NRW'(gh_q);
    passes = PW'(int'(w_eff) * int'(h_eff));
  end

  // goal of the incoming request
  always_comb begin
    int ec, er;
    ec = int'(start_col_i);
    er = int'(start_row_i);
    case (move_dir_i)
      2'd0:    er = er + int'(move_dist_i);
      2'd1:    ec = ec + int'(move_dist_i);
      2'd2:    er = er - int'(move_dist_i);
      default: ec = ec - int'(move_dist_i);
    endcase
    over_new = 1'b0;
    if (ec > int'(w_eff) - 1) begin
      ec = int'(w_eff) - 1;
      over_new = 1'b1;
    end
    if (ec < 0) begin
      ec = 0;
      over_new = 1'b1;
    end
    if (er > int'(h_eff) - 1) er = int'(h_eff) - 1;
    if (er < 0) er = 0;
    ec_new    = CXW'(ec);
    er_new    = RXW'(er);
    start_out = (int'(start_col_i) >= int'(w_eff)) || (int'(start_row_i) >= int'(h_eff));
    start_eq  = (int'(start_col_i) == ec) && (int'(start_row_i) == er);
  end

  assign sweep_last = (int'(sweep_r_q) == int'(h_eff) - 1) && (int'(sweep_c_q) == int'(w_eff) - 1);

  // neighbor k of the cell just picked
  always_comb begin
    nb_c  = best_c;
    nb_r  = best_r;
    nb_ok = 1'b0;
    case (nb_q)
      2'd0: begin
        nb_c  = best_c - CXW'(1);
        nb_ok = (best_c != '0);
      end
      2'd1: begin
        nb_c  = best_c + CXW'(1);
        nb_ok = (int'(best_c) < int'(w_eff) - 1);
      end
      2'd2: begin
        nb_r  = best_r - RXW'(1);
        nb_ok = (best_r != '0);
      end
      default: begin
        nb_r  = best_r + RXW'(1);
        nb_ok = (int'(best_r) < int'(h_eff) - 1);
      end
    endcase
    g_new     = {1'b0, best_g} + (COST_W+1)'(STEP_COST);
    relax_hit = ({1'b0, cost_rd[COST_W-1:0]} > g_new);
    p_c       = from_rd[CXW+RXW-1:RXW];
    p_r       = from_rd[RXW-1:0];
    tr_last   = ((p_c == sc_q) && (p_r == sr_q)) || (cnt_q == NW'(RESULT_CAP - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (start_out || start_eq) state_d = ST_EMIT;
          else state_d = ST_CLEAR;
        end
      end
      ST_CLEAR:     if (sweep_last) state_d = ST_INIT;
      ST_INIT:      state_d = ST_SCAN;
      ST_SCAN:      if (sweep_last) state_d = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!best_vld) state_d = ST_EMIT;
        else if (best_c == ec_q && best_r == er_q) state_d = ST_TR_RD;
        else state_d = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (nb_ok) state_d = ST_NB_WR;
        else if (nb_q == 2'd3) state_d = ST_CLOSE;
      end
      ST_NB_WR: state_d = (nb_q == 2'd3) ? ST_CLOSE : ST_NB_RD;
      ST_CLOSE: state_d = (pass_q + PW'(1) == passes) ? ST_EMIT : ST_SCAN;
      ST_TR_RD: state_d = ST_TR_CHK;
      ST_TR_CHK: begin
        if (out_free) state_d = tr_last ? ST_IDLE : ST_TR_RD;
      end
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    cost_we  = 1'b0;
    cost_wa  = cell_addr(sweep_c_q, sweep_r_q);
    cost_wd  = {1'b0, COST_INF};
    cost_re  = 1'b0;
    cost_ra  = cell_addr(sweep_c_q, sweep_r_q);
    from_we  = 1'b0;
    from_wd  = {best_c, best_r};
    from_re  = 1'b0;
    from_ra  = cell_addr(cur_c_q, cur_r_q);
    best_clr = 1'b0;
    case (state_q)
      ST_CLEAR: cost_we = 1'b1;
      ST_INIT: begin
        cost_we  = 1'b1;
        cost_wa  = cell_addr(sc_q, sr_q);
        cost_wd  = '0;
        best_clr = 1'b1;
      end
      ST_SCAN: cost_re = 1'b1;
      ST_NB_RD: begin
        cost_re = nb_ok;
        cost_ra = cell_addr(nb_c, nb_r);
      end
      ST_NB_WR: begin
        cost_wa = cell_addr(nb_c, nb_r);
        cost_wd = {cost_rd[CW-1], g_new[COST_W-1:0]};
        cost_we = relax_hit;
        from_we = relax_hit;
      end
      ST_CLOSE: begin
        cost_we  = 1'b1;
        cost_wa  = cell_addr(best_c, best_r);
        cost_wd  = {1'b1, best_g};
        best_clr = 1'b1;
      end
      ST_TR_RD: from_re = 1'b1;
      default: ;
    endcase
  end

  gapf_ram #(.W(CW), .D(CELLS)) u_cost_ram (
    .clk_i (clk_i),
    .we_i  (cost_we),
    .wa_i  (cost_wa),
    .wd_i  (cost_wd),
    .re_i  (cost_re),
    .ra_i  (cost_ra),
    .rd_o  (cost_rd)
  );

  gapf_ram #(.W(CXW+RXW), .D(CELLS)) u_from_ram (
    .clk_i (clk_i),
    .we_i  (from_we),
    .wa_i  (cost_wa),
    .wd_i  (from_wd),
    .re_i  (from_re),
    .ra_i  (from_ra),
    .rd_o  (from_rd)
  );

  gapf_best #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (best_clr),
    .vld_i      (scan_vld_q),
    .c_i        (scan_c_q),
    .r_i        (scan_r_q),
    .closed_i   (cost_rd[CW-1]),
    .cost_i     (cost_rd[COST_W-1:0]),
    .ec_i       (ec_q),
    .er_i       (er_q),
    .best_vld_o (best_vld),
    .best_c_o   (best_c),
    .best_r_o   (best_r),
    .best_g_o   (best_g)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gw_q       <= GRID_WIDTH_RST;
      gh_q       <= GRID_HEIGHT_RST;
      out_vld_q  <= 1'b0;
      scan_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH:  gw_q <= cfg_data_i;
          CFG_GRID_HEIGHT: gh_q <= cfg_data_i;
          default: ;
        endcase
      end
      scan_vld_q <= (state_q == ST_SCAN);
      if (((state_q == ST_EMIT) || (state_q == ST_TR_CHK)) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_c_q <= sweep_c_q;
    scan_r_q <= sweep_r_q;
    if (accept) begin
      sc_q         <= CXW'(start_col_i);
      sr_q         <= RXW'(start_row_i);
      ec_q         <= ec_new;
      er_q         <= er_new;
      over_q       <= over_new;
      emit_found_q <= !start_out;
      sweep_c_q    <= '0;
      sweep_r_q    <= '0;
    end
    // advance the column-major sweep
    if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
      if (int'(sweep_r_q) == int'(h_eff) - 1) begin
        sweep_r_q <= '0;
        sweep_c_q <= sweep_c_q + CXW'(1);
      end else begin
        sweep_r_q <= sweep_r_q + RXW'(1);
      end
    end
    if ((state_q == ST_INIT) || (state_q == ST_CLOSE)) begin
      sweep_c_q <= '0;
      sweep_r_q <= '0;
    end
    if (state_q == ST_INIT) pass_q <= '0;
    if (state_q == ST_CLOSE) begin
      pass_q <= pass_q + PW'(1);
      if (state_d == ST_EMIT) emit_found_q <= 1'b0;
    end
    if (state_q == ST_DECIDE) begin
      nb_q    <= 2'd0;
      cur_c_q <= ec_q;
      cur_r_q <= er_q;
      cnt_q   <= '0;
      if (!best_vld) emit_found_q <= 1'b0;
    end
    if ((state_q == ST_NB_RD && !nb_ok) || (state_q == ST_NB_WR)) nb_q <= nb_q + 2'd1;
    if (state_q == ST_TR_CHK && out_free) begin
      out_col_q   <= 4'(cur_c_q);
      out_row_q   <= 4'(cur_r_q);
      out_found_q <= 1'b1;
      out_over_q  <= over_q;
      out_last_q  <= tr_last;
      cur_c_q     <= p_c;
      cur_r_q     <= p_r;
      cnt_q       <= cnt_q + NW'(1);
    end
    if (state_q == ST_EMIT && out_free) begin
      out_col_q   <= emit_found_q ? 4'(ec_q) : 4'd0;
      out_row_q   <= emit_found_q ? 4'(er_q) : 4'd0;
      out_found_q <= emit_found_q;
      out_over_q  <= over_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign path_col_o  = out_col_q;
  assign path_row_o  = out_row_q;
  assign found_o     = out_found_q;
  assign went_over_o = out_over_q;
  assign last_o      = out_last_q;

endmodule

/* rtl/gapf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gapf_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wa_i,
  input  logic [W-1:0]  wd_i,
  input  logic          re_i,
  input  logic [AW-1:0] ra_i,
  output logic [W-1:0]  rd_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem_q[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

/* rtl/gapf_best.sv */
// Scan unit: takes one cost word per cycle in scan order and keeps the first open cell of least F.
// Depends on gapf_pkg.
module gapf_best #(
  parameter int MAX_COLS = gapf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gapf_pkg::MAX_ROWS_DEF,
  localparam int CXW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RXW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      vld_i,
  input  logic [CXW-1:0]            c_i,
  input  logic [RXW-1:0]            r_i,
  input  logic                      closed_i,
  input  logic [gapf_pkg::COST_W-1:0] cost_i,
  input  logic [CXW-1:0]            ec_i,
  input  logic [RXW-1:0]            er_i,
  output logic                      best_vld_o,
  output logic [CXW-1:0]            best_c_o,
  output logic [RXW-1:0]            best_r_o,
  output logic [gapf_pkg::COST_W-1:0] best_g_o
);
  import gapf_pkg::*;

  localparam int FMAX = 4095 + STEP_COST * (MAX_COLS + MAX_ROWS - 2);
  localparam int FW   = $clog2(FMAX + 1);

  logic [CXW-1:0] dc;
  logic [RXW-1:0] dr;
  logic [FW-1:0]  dsum;
  logic [FW-1:0]  f;
  logic           take;

  logic              best_vld_q;
  logic [FW-1:0]     best_f_q;
  logic [CXW-1:0]    best_c_q;
  logic [RXW-1:0]    best_r_q;
  logic [COST_W-1:0] best_g_q;

  always_comb begin
    dc   = (c_i > ec_i) ? (c_i - ec_i) : (ec_i - c_i);
    dr   = (r_i > er_i) ? (r_i - er_i) : (er_i - r_i);
    dsum = FW'(dc) + FW'(dr);
    f    = FW'(cost_i) + (dsum << 3) + (dsum << 1);
    take = vld_i && !closed_i && (cost_i != COST_INF) && (!best_vld_q || (f < best_f_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else if (clr_i) begin
      best_vld_q <= 1'b0;
    end else if (take) begin
      best_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_f_q <= f;
      best_c_q <= c_i;
      best_r_q <= r_i;
      best_g_q <= cost_i;
    end
  end

  assign best_vld_o = best_vld_q;
  assign best_c_o   = best_c_q;
  assign best_r_o   = best_r_q;
  assign best_g_o   = best_g_q;

endmodule

/* test/tb_top.sv */
// Testbench for grid_astar_path_finder_top: path requests under several grid sizes, checked
// result by result against an A* path predictor kept in the bench. Depends on gapf_pkg.
`timescale 1ns / 100ps

module tb_top;
  import gapf_pkg::*;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
    logic [1:0] dir;
    logic [3:0] span;
  } route_req_t;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
    logic       found;
    logic       over;
    logic       last;
  } path_cell_t;

  localparam int NCELL = 256;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [3:0] start_col_i, start_row_i, move_dist_i;
  logic [1:0] move_dir_i;
  logic out_valid_o, out_stall_i;
  logic [3:0] path_col_o, path_row_o;
  logic found_o, went_over_o, last_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  grid_astar_path_finder_top DUT (.*);

  route_req_t pending_reqs[$];
  path_cell_t expected_cells[$];
  int grid_w = 9, grid_h = 4;
  int mismatches = 0;
  bit quiet = 0;
  int hold_asked = 0, hold_served = 0, hold_left = 0;

  logic [11:0] g_cost[NCELL];
  int          g_from[NCELL];
  bit          g_closed[NCELL];

  initial for (int i = 0; i < NCELL; i++) g_from[i] = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int absdiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  // Expected path cells for one request, goal first.
  task automatic predict_path(route_req_t rq);
    int w, h, sc, sr, ec, er, goal, start, best, bestf, f, bc, br, cur, p, n;
    bit over, ok;
    path_cell_t cells[$];
    w = grid_w < 1 ? 1 : (grid_w > 16 ? 16 : grid_w);
    h = grid_h < 1 ? 1 : (grid_h > 16 ? 16 : grid_h);
    sc = rq.col; sr = rq.row; ec = sc; er = sr; over = 0; ok = 0;
    case (rq.dir)
      2'd0: er += rq.span;
      2'd1: ec += rq.span;
      2'd2: er -= rq.span;
      default: ec -= rq.span;
    endcase
    if (ec > w - 1) begin ec = w - 1; over = 1; end
    if (ec < 0) begin ec = 0; over = 1; end
    if (er > h - 1) er = h - 1;
    if (er < 0) er = 0;
    if (sc >= w || sr >= h) begin
      expected_cells.push_back('{4'd0, 4'd0, 1'b0, over, 1'b1});
      return;
    end
    if (sc == ec && sr == er) begin
      expected_cells.push_back('{ec[3:0], er[3:0], 1'b1, over, 1'b1});
      return;
    end
    for (int c = 0; c < w; c++)
      for (int r = 0; r < h; r++) begin
        g_cost[c*16+r] = COST_INF;
        g_closed[c*16+r] = 0;
      end
    start = sc*16 + sr;
    goal = ec*16 + er;
    g_cost[start] = 0;
    for (int pass = 0; pass < w*h; pass++) begin
      best = 0;
      bestf = 32'h7fffffff;
      for (int c = 0; c < w; c++)
        for (int r = 0; r < h; r++)
          if (!g_closed[c*16+r] && g_cost[c*16+r] != COST_INF) begin
            f = g_cost[c*16+r] + STEP_COST * (absdiff(c, ec) + absdiff(r, er));
            if (f < bestf) begin bestf = f; best = c*16+r; end
          end
      if (bestf == 32'h7fffffff) break;
      if (best == goal) begin ok = 1; break; end
      bc = best / 16;
      br = best % 16;
      for (int k = 0; k < 4; k++) begin
        int nb;
        bit en;
        case (k)
          0: begin en = bc != 0;     nb = best - 16; end
          1: begin en = bc < w - 1;  nb = best + 16; end
          2: begin en = br != 0;     nb = best - 1; end
          default: begin en = br < h - 1; nb = best + 1; end
        endcase
        if (en && int'(g_cost[nb]) > int'(g_cost[best]) + STEP_COST) begin
          g_cost[nb] = g_cost[best] + STEP_COST;
          g_from[nb] = best;
        end
      end
      g_closed[best] = 1;
    end
    if (!ok) begin
      expected_cells.push_back('{4'd0, 4'd0, 1'b0, over, 1'b1});
      return;
    end
    cells.push_back('{ec[3:0], er[3:0], 1'b1, over, 1'b0});
    cur = goal;
    n = 1;
    while (n < RESULT_CAP) begin
      p = g_from[cur] % NCELL;
      if (p == start) break;
      cells.push_back('{p[7:4], p[3:0], 1'b1, over, 1'b0});
      n++;
      cur = p;
    end
    cells[cells.size()-1].last = 1'b1;
    foreach (cells[i]) expected_cells.push_back(cells[i]);
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // Driver: present the next request once the current one is taken.
  route_req_t cur_req;
  int req_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_path(cur_req);
      if (req_gap > 0) begin
        req_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        start_col_i <= cur_req.col;
        start_row_i <= cur_req.row;
        move_dir_i <= cur_req.dir;
        move_dist_i <= cur_req.span;
        in_valid_i <= 1'b1;
        req_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_served < hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left <= 3000;
    end
  end

  // Monitor: check each taken result, then choose the next stall.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result col=%0d row=%0d found=%0b", path_col_o, path_row_o,
                     found_o);
        end else begin
          path_cell_t e;
          e = expected_cells.pop_front();
          if (e.col !== path_col_o || e.row !== path_row_o || e.found !== found_o ||
              e.over !== went_over_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp col=%0d row=%0d f=%0b o=%0b l=%0b got %0d %0d %0b %0b %0b",
                       e.col, e.row, e.found, e.over, e.last, path_col_o, path_row_o,
                       found_o, went_over_o, last_o);
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 3);
      out_stall_i <= (hold_left > 0) || (stall_left > 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DAT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(int w, int h);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    grid_w = w;
    grid_h = h;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_cells.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic route_req_t rand_req();
    route_req_t rq;
    int w, h;
    w = grid_w < 1 ? 1 : (grid_w > 16 ? 16 : grid_w);
    h = grid_h < 1 ? 1 : (grid_h > 16 ? 16 : grid_h);
    rq.col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, w - 1);
    rq.row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, h - 1);
    rq.dir = $urandom_range(0, 3);
    rq.span = $urandom_range(0, 15);
    return rq;
  endfunction

  int phase_w[9] = '{9, 1, 16, 0, 31, 4, 16, 6, 3};
  int phase_h[9] = '{4, 1, 16, 0, 31, 16, 2, 5, 3};
  int phase_n[9] = '{14, 14, 6, 14, 6, 18, 18, 18, 18};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    start_col_i = '0;
    start_row_i = '0;
    move_dir_i = '0;
    move_dist_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // Directed requests on the reset grid: corners, all directions, clamps, bad start.
    pending_reqs.push_back('{4'd0, 4'd0, 2'd0, 4'd0});
    pending_reqs.push_back('{4'd0, 4'd0, 2'd0, 4'd3});
    pending_reqs.push_back('{4'd0, 4'd0, 2'd1, 4'd8});
    pending_reqs.push_back('{4'd0, 4'd0, 2'd1, 4'd15});
    pending_reqs.push_back('{4'd8, 4'd3, 2'd2, 4'd3});
    pending_reqs.push_back('{4'd8, 4'd3, 2'd3, 4'd15});
    pending_reqs.push_back('{4'd8, 4'd3, 2'd0, 4'd15});
    pending_reqs.push_back('{4'd4, 4'd1, 2'd2, 4'd15});
    pending_reqs.push_back('{4'd4, 4'd2, 2'd3, 4'd4});
    pending_reqs.push_back('{4'd3, 4'd0, 2'd1, 4'd5});
    pending_reqs.push_back('{4'd15, 4'd0, 2'd3, 4'd2});
    pending_reqs.push_back('{4'd2, 4'd15, 2'd0, 4'd1});
    pending_reqs.push_back('{4'd15, 4'd15, 2'd2, 4'd15});
    pending_reqs.push_back('{4'd8, 4'd0, 2'd1, 4'd1});
    pending_reqs.push_back('{4'd0, 4'd3, 2'd3, 4'd1});
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      set_grid(phase_w[ph], phase_h[ph]);
      quiet = (ph == 5) || (ph == 7);
      // Hold the output for a long stretch while requests keep coming.
      if (ph == 5) hold_asked++;
      for (int i = 0; i < phase_n[ph]; i++) pending_reqs.push_back(rand_req());
      drain();
    end
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
